// ===== design/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared widths, payload structs and elaboration-time helpers of the sigmoid
// forward/backward core.
// ----------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

    // fixed field widths
    localparam int unsigned X_W        = 16;
    localparam int unsigned GRAD_W     = 16;
    // exp(-t) in Q.32, the value 1.0 needs the extra bit
    localparam int unsigned EXP_W      = 33;
    localparam int unsigned M1_W       = 32;
    // integer part above which exp(-x) is taken as zero
    localparam int unsigned EXP_CUTOFF = 40;
    // register stages inside the gradient path
    localparam int unsigned GRAD_LAT   = 4;

    localparam logic KIND_FWD = 1'b0;
    localparam logic KIND_BWD = 1'b1;

    typedef struct packed {
        logic kind;
        logic x_neg;
    } sfb_side_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] value;
        logic                     sat;
    } sfb_grad_t;

    // exp(-f / 2^frac_bits) in Q.32 from the alternating series, 31 terms in Q.48,
    // each term floored; only evaluated at elaboration
    function automatic logic [EXP_W-1:0] exp_neg_frac(input int unsigned frac_bits,
                                                      input logic [31:0] f);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        int unsigned k;
        term = 64'd1 << 48;
        sum  = term;
        for (k = 1; k <= 30; k++) begin
            num = (term * {32'd0, f}) >> frac_bits;
            // shift-subtract division by the term index
            quo = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= 64'(k)) begin
                    rem    = rem - 64'(k);
                    quo[b] = 1'b1;
                end
            end
            term = quo;
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return EXP_W'((sum + (64'd1 << 15)) >> 16);
    endfunction

    // number of exp(-1) multiply stages for a given input format
    function automatic int unsigned mul_stages(input int unsigned in_frac_bits);
        int unsigned n_max;
        n_max = 1 << (X_W - 1 - in_frac_bits);
        return (n_max > EXP_CUTOFF) ? EXP_CUTOFF : n_max;
    endfunction

endpackage

`default_nettype wire

// ===== design/sfb_exp_rom.sv =====
// ----------------------------------------------------------------------------
// sfb_exp_rom
// Splits |x| into integer and fraction parts and looks up exp(-fraction)
// in a constant table with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_exp_rom #(
    parameter int unsigned IN_FRAC_BITS = 11
) (
    input  logic                                      clk,
    input  logic                                      adv,
    input  logic signed [sfb_pkg::X_W-1:0]            x_value,
    output logic [sfb_pkg::EXP_W-1:0]                 e_out,
    output logic [sfb_pkg::X_W-IN_FRAC_BITS-1:0]      n_out
);
    import sfb_pkg::*;

    localparam int unsigned N_W         = X_W - IN_FRAC_BITS;
    localparam int unsigned FRAC_VALUES = 1 << IN_FRAC_BITS;

    logic [EXP_W-1:0]        exp_rom [FRAC_VALUES];
    logic [X_W-1:0]          x_bits;
    logic [X_W-1:0]          x_abs;
    logic [N_W-1:0]          n_int;
    logic [IN_FRAC_BITS-1:0] frac;
    logic [EXP_W-1:0]        e_reg;
    logic [N_W-1:0]          n_reg;

    // table contents worked out at elaboration
    for (genvar i = 0; i < FRAC_VALUES; i++) begin : g_rom
        localparam logic [EXP_W-1:0] ENTRY = exp_neg_frac(IN_FRAC_BITS, 32'(i));
        assign exp_rom[i] = ENTRY;
    end

    assign x_bits = x_value;
    assign x_abs  = x_bits[X_W-1] ? (~x_bits + 16'd1) : x_bits;
    assign n_int  = x_abs[X_W-1:IN_FRAC_BITS];
    assign frac   = x_abs[IN_FRAC_BITS-1:0];

    always_ff @(posedge clk) begin
        if (adv) begin
            e_reg <= (32'(n_int) > EXP_CUTOFF) ? '0 : exp_rom[frac];
            n_reg <= n_int;
        end
    end

    assign e_out = e_reg;
    assign n_out = n_reg;

endmodule

`default_nettype wire

// ===== design/sfb_exp_pow.sv =====
// ----------------------------------------------------------------------------
// sfb_exp_pow
// Scales exp(-fraction) by exp(-1) once per integer unit of |x|, one
// rounded multiply per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_exp_pow #(
    parameter int unsigned IN_FRAC_BITS = 11
) (
    input  logic                                      clk,
    input  logic                                      adv,
    input  logic [sfb_pkg::EXP_W-1:0]                 e_in,
    input  logic [sfb_pkg::X_W-IN_FRAC_BITS-1:0]      n_in,
    output logic [sfb_pkg::EXP_W-1:0]                 e_out
);
    import sfb_pkg::*;

    localparam int unsigned N_W        = X_W - IN_FRAC_BITS;
    localparam int unsigned MUL_STAGES = mul_stages(IN_FRAC_BITS);
    localparam int unsigned PROD_W     = EXP_W + M1_W;
    localparam logic [M1_W-1:0] M1     =
        M1_W'(exp_neg_frac(IN_FRAC_BITS, 32'(1) << IN_FRAC_BITS));
    localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (M1_W - 1);

    logic [EXP_W-1:0] e_reg [MUL_STAGES];
    logic [N_W-1:0]   n_reg [MUL_STAGES-1];

    for (genvar j = 0; j < MUL_STAGES; j++) begin : g_stage
        logic [EXP_W-1:0]  e_src;
        logic [N_W-1:0]    n_src;
        logic [PROD_W-1:0] prod;
        logic [EXP_W-1:0]  e_next;

        if (j == 0) begin : g_first
            assign e_src = e_in;
            assign n_src = n_in;
        end else begin : g_rest
            assign e_src = e_reg[j-1];
            assign n_src = n_reg[j-1];
        end

        // e * exp(-1) in Q.32, rounded to nearest
        assign prod   = PROD_W'(e_src) * PROD_W'(M1) + ROUND;
        assign e_next = (32'(n_src) > 32'(j)) ? prod[PROD_W-1:M1_W] : e_src;

        always_ff @(posedge clk) begin
            if (adv) begin
                e_reg[j] <= e_next;
            end
        end

        if (j < MUL_STAGES - 1) begin : g_cnt
            always_ff @(posedge clk) begin
                if (adv) begin
                    n_reg[j] <= n_src;
                end
            end
        end
    end

    assign e_out = e_reg[MUL_STAGES-1];

endmodule

`default_nettype wire

// ===== design/sfb_recip_div.sv =====
// ----------------------------------------------------------------------------
// sfb_recip_div
// Rounded reciprocal 2^(OUT_FRAC_BITS+32) / (2^32 + e), one quotient bit
// per pipeline stage (restoring division).
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_recip_div #(
    parameter int unsigned OUT_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [sfb_pkg::EXP_W-1:0]     e_in,
    output logic [OUT_FRAC_BITS:0]        quot
);
    import sfb_pkg::*;

    localparam int unsigned QW = OUT_FRAC_BITS + 1;
    localparam int unsigned DW = EXP_W + 1;
    localparam int unsigned NW = OUT_FRAC_BITS + EXP_W;

    logic [DW-1:0] d_init;
    logic [NW-1:0] num;
    logic [DW-1:0] rem_init;

    logic [DW-1:0] rem_reg [QW-1];
    logic [DW-1:0] d_reg   [QW-1];
    logic [QW-1:0] low_reg [QW-1];
    logic [QW-1:0] q_reg   [QW];

    // divisor and numerator with the half-divisor rounding term
    assign d_init   = DW'(e_in) + (DW'(1) << (EXP_W - 1));
    assign num      = (NW'(1) << (OUT_FRAC_BITS + EXP_W - 1)) + NW'(d_init >> 1);
    assign rem_init = DW'(num >> QW);

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [DW-1:0] rem_src;
        logic [DW-1:0] d_src;
        logic [QW-1:0] low_src;
        logic [QW-1:0] q_src;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] q_next;

        if (j == 0) begin : g_first
            assign rem_src = rem_init;
            assign d_src   = d_init;
            assign low_src = num[QW-1:0];
            assign q_src   = '0;
        end else begin : g_rest
            assign rem_src = rem_reg[j-1];
            assign d_src   = d_reg[j-1];
            assign low_src = low_reg[j-1];
            assign q_src   = q_reg[j-1];
        end

        assign trial    = {rem_src, low_src[QW-1-j]};
        assign ge       = trial >= (DW+1)'(d_src);
        assign rem_next = ge ? DW'(trial - (DW+1)'(d_src)) : DW'(trial);
        assign q_next   = q_src | (QW'(ge) << (QW - 1 - j));

        always_ff @(posedge clk) begin
            if (adv) begin
                q_reg[j] <= q_next;
            end
        end

        if (j < QW - 1) begin : g_carry
            always_ff @(posedge clk) begin
                if (adv) begin
                    rem_reg[j] <= rem_next;
                    d_reg[j]   <= d_src;
                    low_reg[j] <= low_src;
                end
            end
        end
    end

    assign quot = q_reg[QW-1];

endmodule

`default_nettype wire

// ===== design/sfb_grad.sv =====
// ----------------------------------------------------------------------------
// sfb_grad
// Backward path: g * y * (1 - y) with round half away from zero,
// four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_grad #(
    parameter int unsigned OUT_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                adv,
    input  logic [OUT_FRAC_BITS:0]              y_value,
    input  logic signed [sfb_pkg::GRAD_W-1:0]   grad_value,
    output sfb_pkg::sfb_grad_t                  grad_out
);
    import sfb_pkg::*;

    localparam int unsigned YW = OUT_FRAC_BITS + 1;
    localparam int unsigned UW = 2 * OUT_FRAC_BITS - 1;
    localparam int unsigned MW = GRAD_W + UW;
    localparam int unsigned SW = MW + 1;
    localparam int unsigned SH = 2 * OUT_FRAC_BITS;
    localparam logic [YW-1:0] ONE  = YW'(1) << OUT_FRAC_BITS;
    localparam logic [SW-1:0] HALF = SW'(1) << (SH - 1);
    localparam logic signed [GRAD_W:0] G_MAX = {2'b00, {(GRAD_W-1){1'b1}}};
    localparam logic signed [GRAD_W:0] G_MIN = {2'b11, {(GRAD_W-1){1'b0}}};

    logic [GRAD_W-1:0] g_bits;
    logic [GRAD_W-1:0] g_mag;

    // stage 1: clamp y, split the sign of g
    logic [YW-1:0]     yc_reg;
    logic              ysat1_reg;
    logic              gneg1_reg;
    logic [GRAD_W-1:0] gmag1_reg;
    // stage 2: y * (1 - y)
    logic [UW-1:0]     u_reg;
    logic              ysat2_reg;
    logic              gneg2_reg;
    logic [GRAD_W-1:0] gmag2_reg;
    // stage 3: |g| * u
    logic [MW-1:0]     m_reg;
    logic              ysat3_reg;
    logic              gneg3_reg;
    // stage 4: round, sign, clamp
    logic [SW-1:0]         sum;
    logic [GRAD_W-1:0]     q_mag;
    logic signed [GRAD_W:0] q_signed;
    logic signed [GRAD_W:0] res;
    sfb_grad_t             grad_next;
    sfb_grad_t             grad_reg;

    assign g_bits = grad_value;
    assign g_mag  = g_bits[GRAD_W-1] ? (~g_bits + 16'd1) : g_bits;

    always_comb begin
        sum      = SW'(m_reg) + HALF;
        q_mag    = sum[SW-1:SH];
        q_signed = signed'({1'b0, q_mag});
        res      = gneg3_reg ? -q_signed : q_signed;
        grad_next.sat = ysat3_reg;
        if (res > G_MAX) begin
            grad_next.value = G_MAX[GRAD_W-1:0];
            grad_next.sat   = 1'b1;
        end else if (res < G_MIN) begin
            grad_next.value = G_MIN[GRAD_W-1:0];
            grad_next.sat   = 1'b1;
        end else begin
            grad_next.value = res[GRAD_W-1:0];
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            yc_reg    <= (y_value > ONE) ? ONE : y_value;
            ysat1_reg <= y_value > ONE;
            gneg1_reg <= g_bits[GRAD_W-1];
            gmag1_reg <= g_mag;

            u_reg     <= UW'(UW'(yc_reg) * UW'(ONE - yc_reg));
            ysat2_reg <= ysat1_reg;
            gneg2_reg <= gneg1_reg;
            gmag2_reg <= gmag1_reg;

            m_reg     <= MW'(gmag2_reg) * MW'(u_reg);
            ysat3_reg <= ysat2_reg;
            gneg3_reg <= gneg2_reg;

            grad_reg  <= grad_next;
        end
    end

    assign grad_out = grad_reg;

endmodule

`default_nettype wire

// ===== design/sigmoid_forward_backward_core.sv =====
// ----------------------------------------------------------------------------
// sigmoid_forward_backward_core
// Element-wise logistic sigmoid with its gradient, fully pipelined.
// ----------------------------------------------------------------------------
// usage
//   input channel (item_valid / item_stall): kind, x_value, y_value,
//   grad_value; an item is taken on a rising edge with item_valid high and
//   item_stall low. kind 0 returns sigmoid(x) in sigmoid_result, kind 1
//   returns grad * y * (1 - y) in grad_result; the unused field reads zero
//   output channel (result_valid / result_stall): one result item per input
//   item, in order; saturated marks a result on a bound or a clamped y_value
//   throughput: one item per clock when not stalled; every stage holds a
//   valid bit and moves together, so items may enter back to back with no gaps
//   path: an accepted item passes the table read register, the exp(-1)
//   multiply chain (one stage per integer unit of |x|, up to 16), the
//   one-bit-per-stage reciprocal divider (OUT_FRAC_BITS+1 stages) and
//   the output register on its way to result_valid
//   stall: while a result waits with result_stall high the whole pipeline
//   freezes and item_stall is raised; nothing is dropped or repeated
//   reset: rst_n clears all valid bits, the block is ready the next cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sigmoid_forward_backward_core #(
    parameter int unsigned IN_FRAC_BITS  = 11,
    parameter int unsigned OUT_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                kind,
    input  logic signed [sfb_pkg::X_W-1:0]      x_value,
    input  logic [OUT_FRAC_BITS:0]              y_value,
    input  logic signed [sfb_pkg::GRAD_W-1:0]   grad_value,
    // result items
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [OUT_FRAC_BITS:0]              sigmoid_result,
    output logic signed [sfb_pkg::GRAD_W-1:0]   grad_result,
    output logic                                saturated
);
    import sfb_pkg::*;

    localparam int unsigned N_W        = X_W - IN_FRAC_BITS;
    localparam int unsigned QW         = OUT_FRAC_BITS + 1;
    localparam int unsigned MUL_STAGES = mul_stages(IN_FRAC_BITS);
    // stages ahead of the output register
    localparam int unsigned FWD_LAT    = 1 + MUL_STAGES + QW;
    // extra delay that lines the gradient path up with the forward path
    localparam int unsigned GD_LEN     = FWD_LAT - GRAD_LAT;
    localparam logic [QW-1:0] ONE      = QW'(1) << OUT_FRAC_BITS;

    // global advance: everything moves unless a finished result is held
    logic adv;

    logic [FWD_LAT-1:0] vld_reg;
    sfb_side_t          side_reg [FWD_LAT];
    sfb_grad_t          grad_dly_reg [GD_LEN];

    logic [EXP_W-1:0]   e_rom;
    logic [N_W-1:0]     n_rom;
    logic [EXP_W-1:0]   e_pow;
    logic [QW-1:0]      r_div;
    sfb_grad_t          grad_path;

    sfb_side_t          side_last;
    sfb_grad_t          grad_last;
    logic [QW-1:0]      r_clamp;
    logic [QW-1:0]      s_fwd;

    logic               result_valid_reg;
    logic [QW-1:0]      sigmoid_next;
    logic [QW-1:0]      sigmoid_reg;
    logic [GRAD_W-1:0]  grad_next;
    logic [GRAD_W-1:0]  grad_reg;
    logic               sat_next;
    logic               sat_reg;

    assign adv        = !(result_valid_reg && result_stall);
    assign item_stall = !adv;

    // forward path: table lookup, exp(-1) powers, reciprocal
    sfb_exp_rom #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_rom (
        .clk     (clk),
        .adv     (adv),
        .x_value (x_value),
        .e_out   (e_rom),
        .n_out   (n_rom)
    );

    sfb_exp_pow #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_pow (
        .clk   (clk),
        .adv   (adv),
        .e_in  (e_rom),
        .n_in  (n_rom),
        .e_out (e_pow)
    );

    sfb_recip_div #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_div (
        .clk  (clk),
        .adv  (adv),
        .e_in (e_pow),
        .quot (r_div)
    );

    // backward path
    sfb_grad #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_grad (
        .clk        (clk),
        .adv        (adv),
        .y_value    (y_value),
        .grad_value (grad_value),
        .grad_out   (grad_path)
    );

    // valid bits, one per stage
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg          <= {vld_reg[FWD_LAT-2:0], item_valid};
            result_valid_reg <= vld_reg[FWD_LAT-1];
        end
    end

    // kind and sign of x ride alongside the forward path
    always_ff @(posedge clk) begin
        if (adv) begin
            side_reg[0].kind  <= kind;
            side_reg[0].x_neg <= x_value[X_W-1];
            for (int i = 1; i < FWD_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // gradient result delay line
    always_ff @(posedge clk) begin
        if (adv) begin
            grad_dly_reg[0] <= grad_path;
            for (int i = 1; i < GD_LEN; i++) begin
                grad_dly_reg[i] <= grad_dly_reg[i-1];
            end
        end
    end

    assign side_last = side_reg[FWD_LAT-1];
    assign grad_last = grad_dly_reg[GD_LEN-1];

    // mirror for negative x: sigmoid(-a) = 1 - sigmoid(a)
    assign r_clamp = (r_div > ONE) ? ONE : r_div;
    assign s_fwd   = side_last.x_neg ? (ONE - r_clamp) : r_clamp;

    always_comb begin
        if (side_last.kind == KIND_FWD) begin
            sigmoid_next = s_fwd;
            grad_next    = '0;
            sat_next     = (s_fwd == '0) || (s_fwd == ONE);
        end else begin
            sigmoid_next = '0;
            grad_next    = grad_last.value;
            sat_next     = grad_last.sat;
        end
    end

    // output register
    always_ff @(posedge clk) begin
        if (adv) begin
            sigmoid_reg <= sigmoid_next;
            grad_reg    <= grad_next;
            sat_reg     <= sat_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign sigmoid_result = sigmoid_reg;
    assign grad_result    = signed'(grad_reg);
    assign saturated      = sat_reg;

endmodule

`default_nettype wire
